### src/grm_pkg.sv
package grm_pkg;

    localparam int GRID_DIM_DEF  = 16;
    localparam int MAX_CROSSINGS = 48;
    localparam int STEP_W        = 6;
    localparam int Q_FRAC        = 16;
    localparam int COORD_W       = 30;
    localparam int MUL_W         = 27;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int NUM_W         = 53;
    localparam int DEN_W         = 27;
    localparam int QUOT_W        = 27;
    localparam int EPS_W         = 11;
    localparam int CLIP_W        = 4;
    localparam int FIELD_W       = 24;
    localparam int PADDR_W       = 3;

    localparam logic [CLIP_W-1:0] CLIP_RST = CLIP_W'(10);
    localparam logic [EPS_W-1:0]  EPS_RST  = EPS_W'(66);

    localparam logic REG_CLIP = 1'b0;
    localparam logic REG_EPS  = 1'b1;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CAST  = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [3:0]                cell_col;
        logic [3:0]                cell_row;
        logic [3:0]                cell_code;
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] through_x;
        logic signed [FIELD_W-1:0] through_y;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] hit_x;
        logic signed [FIELD_W-1:0] hit_y;
        logic [3:0]                hit_col;
        logic [3:0]                hit_row;
        logic [3:0]                wall_code;
        logic                      hit_flag;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [QUOT_W:0] quot;
    } t_div_rsp;

endpackage

### src/grm_in_if.sv
interface grm_in_if;
    logic               valid;
    logic               ready;
    grm_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/grm_out_if.sv
interface grm_out_if;
    logic               valid;
    logic               ready;
    grm_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/grm_div.sv
module grm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grm_pkg::t_div_req i_req,
    output grm_pkg::t_div_rsp o_rsp
);
    localparam int QW = grm_pkg::QUOT_W;
    localparam int DW = grm_pkg::DEN_W;
    localparam int NW = grm_pkg::NUM_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [NW+1:0]    n2;
    logic [DW:0]      d2;
    logic             ovf;
    logic [DW+1:0]    trial;
    logic             qbit;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW:0]      r_rem;
    logic [DW:0]      r_den2;
    logic [QW-1:0]    r_nlo;
    logic [QW:0]      r_q;

    // rounded quotient (2n + d) / (2d)
    assign n2    = {1'b0, i_req.num, 1'b0} + (NW+2)'(i_req.den);
    assign d2    = {i_req.den, 1'b0};
    assign ovf   = n2 >= {d2, {QW{1'b0}}};
    assign trial = {r_rem, r_nlo[QW-1]};
    assign qbit  = trial >= {1'b0, r_den2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_den2 <= d2;
                if (ovf) begin
                    // quotient too big for any in-grid result: clamp
                    r_q    <= {1'b1, {QW{1'b0}}};
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= n2[NW+1:QW];
                    r_nlo  <= n2[QW-1:0];
                    r_q    <= '0;
                    r_cnt  <= CNT_W'(QW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (qbit) begin
                    r_rem <= (DW+1)'(trial - {1'b0, r_den2});
                end else begin
                    r_rem <= trial[DW:0];
                end
                r_q   <= {r_q[QW-1:0], qbit};
                r_nlo <= {r_nlo[QW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule

### src/grid_ray_march_unit.sv
// channel   dir  handshake          payload
// i_in      in   valid/ready        mode, cell address/code, start and through points
// o_out     out  valid/ready        hit point, hit cell, wall code, hit flag
// apb       in   psel/penable/...   clip_distance at 0x0, epsilon at 0x4
//
// a cell write is stored as the item is taken; a cast steps through the crossings,
// with the 27 step restoring divider for a crossing that is not axis-parallel (its steps
// skipped when the quotient overflows); up to 48 crossings, then a last check and finish
// after reset a clearing pass writes zero to each of the GRID_DIM*GRID_DIM map cells,
// i_in.ready stays low meanwhile (256 cells at the default grid)
// a finished result waits in the output register; the next item is taken
// while it waits, a second result holds the sequencer until the slot frees
module grid_ray_march_unit #(
    parameter int GRID_DIM = grm_pkg::GRID_DIM_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    grm_in_if.sink                         i_in,
    grm_out_if.source                      o_out,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [grm_pkg::PADDR_W-1:0]    i_paddr,
    input  logic [31:0]                    i_pwdata,
    output logic [31:0]                    o_prdata,
    output logic                           o_pready
);
    localparam int CW     = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int DEPTH  = GRID_DIM * GRID_DIM;
    localparam int AW     = $clog2(DEPTH);
    localparam int XW     = grm_pkg::COORD_W;
    localparam int MW     = grm_pkg::MUL_W;
    localparam int PW     = grm_pkg::PROD_W;
    localparam int FW     = grm_pkg::FIELD_W;
    localparam int EW     = grm_pkg::EPS_W;
    localparam int QF     = grm_pkg::Q_FRAC;
    localparam int CELL_W = XW - QF;
    localparam int SW     = grm_pkg::STEP_W;

    localparam logic signed [XW-1:0]     FRAC_MASK = XW'((1 << QF) - 1);
    localparam logic signed [CELL_W-1:0] GRID_S    = CELL_W'(GRID_DIM);
    localparam logic signed [XW-1:0]     SAT_MAX   = XW'((1 << (FW - 1)) - 1);
    localparam logic signed [XW-1:0]     SAT_MIN   = -XW'(1 << (FW - 1));

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_TRV1  = 4'd2;
    localparam logic [3:0] S_TRV2  = 4'd3;
    localparam logic [3:0] S_TRV3  = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_CMP1  = 4'd6;
    localparam logic [3:0] S_CMP2  = 4'd7;
    localparam logic [3:0] S_SEL   = 4'd8;
    localparam logic [3:0] S_XMUL  = 4'd9;
    localparam logic [3:0] S_XDIV  = 4'd10;
    localparam logic [3:0] S_XDIVW = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    // snap a coordinate across the next grid line in the step direction
    function automatic logic signed [XW-1:0] snap(input logic signed [XW-1:0] v,
                                                  input logic signed [XW-1:0] d,
                                                  input logic [EW-1:0] eps);
        logic signed [XW-1:0] ev;
        ev = XW'(eps);
        if (d > 0) begin
            return (v + ev + FRAC_MASK) & ~FRAC_MASK;
        end else if (d < 0) begin
            return (v - ev) & ~FRAC_MASK;
        end
        return v;
    endfunction

    // cell of a point, nudged by epsilon along the step
    function automatic logic signed [CELL_W-1:0] cell_of(input logic signed [XW-1:0] b,
                                                         input logic signed [XW-1:0] a,
                                                         input logic [EW-1:0] eps);
        logic signed [XW-1:0] ev;
        logic signed [XW-1:0] d;
        logic signed [XW-1:0] bn;
        ev = XW'(eps);
        d  = b - a;
        if (d > 0) begin
            bn = b + ev;
        end else if (d < 0) begin
            bn = b - ev;
        end else begin
            bn = b;
        end
        bn = bn >>> QF;
        return bn[CELL_W-1:0];
    endfunction

    function automatic logic signed [FW-1:0] sat(input logic signed [XW-1:0] v);
        if (v > SAT_MAX) begin
            return SAT_MAX[FW-1:0];
        end else if (v < SAT_MIN) begin
            return SAT_MIN[FW-1:0];
        end
        return v[FW-1:0];
    endfunction

    function automatic logic signed [MW-1:0] absm(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v < 0) ? -v : v;
        return t[MW-1:0];
    endfunction

    // configuration registers
    logic [grm_pkg::CLIP_W-1:0] r_clip;
    logic [EW-1:0]              r_eps;
    logic                       cfg_we;
    logic                       cfg_idx;

    assign cfg_we   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[2];
    assign o_pready = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            grm_pkg::REG_CLIP: o_prdata = 32'(r_clip);
            grm_pkg::REG_EPS:  o_prdata = 32'(r_eps);
            default:           o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip <= grm_pkg::CLIP_RST;
            r_eps  <= grm_pkg::EPS_RST;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                grm_pkg::REG_CLIP: r_clip <= i_pwdata[grm_pkg::CLIP_W-1:0];
                grm_pkg::REG_EPS:  r_eps  <= i_pwdata[EW-1:0];
                default:           r_clip <= r_clip;
            endcase
        end
    end

    // sequencer state
    logic [3:0]            r_state;
    logic [3:0]            n_state;
    logic [AW-1:0]         r_clr;
    logic signed [XW-1:0]  r_sx, r_sy, r_ax, r_ay, r_bx, r_by;
    logic signed [XW-1:0]  r_x3, r_y4, r_dx, r_dy;
    logic [SW-1:0]         r_steps;
    logic [PW-1:0]         r_acc;
    logic signed [PW-1:0]  r_prod;
    logic                  r_tok;
    logic                  r_selx;
    logic                  r_neg;
    logic [3:0]            r_rcol, r_rrow, r_rcode;
    logic                  r_rhit;
    logic                  r_ovalid;
    grm_pkg::t_out_item    r_out;

    // map store
    logic [3:0]            r_mem [DEPTH];
    logic [3:0]            r_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [3:0]            mem_wdata;
    logic [AW-1:0]         mem_raddr;

    // shared multiplier and divider
    logic signed [MW-1:0]  m_a, m_b;
    grm_pkg::t_div_req     div_req;
    grm_pkg::t_div_rsp     div_rsp;

    logic                  in_acc;
    logic                  out_free;
    logic                  wr_in_grid;
    logic signed [CELL_W-1:0] cx, cy;
    logic                  in_grid;
    logic                  travel_ok;
    logic [2*grm_pkg::CLIP_W-1:0] clip_sq;
    logic [PW-1:0]         lim;
    logic signed [XW-1:0]  dx, dy, x3, y4;
    logic signed [XW-1:0]  den;
    logic signed [PW-1:0]  prod_mag;
    logic signed [XW-1:0]  qs;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_ovalid || o_out.ready;

    assign wr_in_grid = (32'(i_in.payload.cell_col) < GRID_DIM) &&
                        (32'(i_in.payload.cell_row) < GRID_DIM);

    assign cx        = cell_of(r_bx, r_ax, r_eps);
    assign cy        = cell_of(r_by, r_ay, r_eps);
    assign in_grid   = (cx >= 0) && (cx < GRID_S) && (cy >= 0) && (cy < GRID_S);
    assign mem_raddr = AW'(32'(cy[CW-1:0]) * GRID_DIM + 32'(cx[CW-1:0]));

    // travel limit clip^2 in squared Q16 units
    assign clip_sq   = r_clip * r_clip;
    assign lim       = PW'({clip_sq, 32'b0});
    assign travel_ok = (r_acc + PW'(r_prod)) < lim;

    assign dx = r_bx - r_ax;
    assign dy = r_by - r_ay;
    assign x3 = snap(r_bx, dx, r_eps);
    assign y4 = snap(r_by, dy, r_eps);

    assign den      = r_selx ? r_dx : r_dy;
    assign prod_mag = (r_prod < 0) ? -r_prod : r_prod;
    assign qs       = r_neg ? -XW'(div_rsp.quot) : XW'(div_rsp.quot);

    assign div_req.start = (r_state == S_XDIV);
    assign div_req.num   = prod_mag[grm_pkg::NUM_W-1:0];
    assign div_req.den   = grm_pkg::DEN_W'(absm(den));

    grm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // operand select for the shared multiplier
    always_comb begin
        unique case (r_state)
            S_TRV1: begin
                m_a = MW'(r_ax - r_sx);
                m_b = MW'(r_ax - r_sx);
            end
            S_TRV2: begin
                m_a = MW'(r_ay - r_sy);
                m_b = MW'(r_ay - r_sy);
            end
            S_CMP1: begin
                m_a = absm(r_x3 - r_bx);
                m_b = absm(r_dy);
            end
            S_CMP2: begin
                m_a = absm(r_y4 - r_by);
                m_b = absm(r_dx);
            end
            S_XMUL: begin
                m_a = r_selx ? MW'(r_x3 - r_ax) : MW'(r_y4 - r_ay);
                m_b = r_selx ? MW'(r_dy) : MW'(r_dx);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // memory port: clearing pass or cell write
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (in_acc && (i_in.payload.mode == grm_pkg::MODE_WRITE) && wr_in_grid) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(32'(i_in.payload.cell_row) * GRID_DIM +
                            32'(i_in.payload.cell_col));
            mem_wdata = i_in.payload.cell_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE:  if (in_acc && (i_in.payload.mode == grm_pkg::MODE_CAST)) n_state = S_TRV1;
            S_TRV1:  n_state = S_TRV2;
            S_TRV2:  n_state = S_TRV3;
            S_TRV3:  n_state = in_grid ? S_CHK : S_DONE;
            S_CHK: begin
                priority if (!r_tok || (r_rdata != '0) ||
                             (r_steps >= SW'(grm_pkg::MAX_CROSSINGS))) begin
                    n_state = S_DONE;
                end else if ((dx == 0) || (dy == 0)) begin
                    n_state = S_TRV1;
                end else begin
                    n_state = S_CMP1;
                end
            end
            S_CMP1:  n_state = S_CMP2;
            S_CMP2:  n_state = S_SEL;
            S_SEL:   n_state = S_XMUL;
            S_XMUL:  n_state = S_XDIV;
            S_XDIV:  n_state = S_XDIVW;
            S_XDIVW: if (div_rsp.done) n_state = S_TRV1;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_sx    <= XW'(i_in.payload.start_x);
                r_sy    <= XW'(i_in.payload.start_y);
                r_ax    <= XW'(i_in.payload.start_x);
                r_ay    <= XW'(i_in.payload.start_y);
                r_bx    <= XW'(i_in.payload.through_x);
                r_by    <= XW'(i_in.payload.through_y);
                r_steps <= '0;
            end
            S_TRV2: r_acc <= PW'(r_prod);
            S_TRV3: begin
                r_tok   <= travel_ok;
                r_rcode <= '0;
                r_rhit  <= 1'b0;
                if (in_grid) begin
                    r_rcol <= cx[3:0];
                    r_rrow <= cy[3:0];
                end else begin
                    // outside the grid: a miss with cell zero
                    r_rcol <= '0;
                    r_rrow <= '0;
                end
            end
            S_CHK: begin
                r_dx <= dx;
                r_dy <= dy;
                r_x3 <= x3;
                r_y4 <= y4;
                if (r_tok && (r_rdata != '0)) begin
                    r_rcode <= r_rdata;
                    r_rhit  <= 1'b1;
                end
                if (r_tok && (r_rdata == '0) &&
                    (r_steps < SW'(grm_pkg::MAX_CROSSINGS))) begin
                    // axis-parallel steps need no division
                    if (dx == 0) begin
                        r_ax    <= r_bx;
                        r_ay    <= r_by;
                        r_by    <= y4;
                        r_steps <= r_steps + 1'b1;
                    end else if (dy == 0) begin
                        r_ax    <= r_bx;
                        r_ay    <= r_by;
                        r_bx    <= x3;
                        r_steps <= r_steps + 1'b1;
                    end
                end
            end
            S_CMP2: r_acc <= PW'(r_prod);
            // the vertical-line crossing only when strictly nearer
            S_SEL:  r_selx <= r_acc < PW'(r_prod);
            S_XDIV: r_neg  <= (r_prod < 0) != (den < 0);
            S_XDIVW: begin
                if (div_rsp.done) begin
                    r_ax    <= r_bx;
                    r_ay    <= r_by;
                    r_steps <= r_steps + 1'b1;
                    if (r_selx) begin
                        r_bx <= r_x3;
                        r_by <= r_ay + qs;
                    end else begin
                        r_by <= r_y4;
                        r_bx <= r_ax + qs;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_out.hit_x     <= sat(r_bx);
                    r_out.hit_y     <= sat(r_by);
                    r_out.hit_col   <= r_rcol;
                    r_out.hit_row   <= r_rrow;
                    r_out.wall_code <= r_rcode;
                    r_out.hit_flag  <= r_rhit;
                end
            end
            default: r_acc <= r_acc;
        endcase
    end

    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;

`ifndef NO_ASSERTIONS
    // no item is taken while the map is being cleared
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("item accepted during map clear");

    // crossing count never passes its bound while a ray is traced
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != S_CLEAR) && (r_state != S_IDLE)) |->
        (r_steps <= SW'(grm_pkg::MAX_CROSSINGS)))
        else $error("crossing count out of range");

    // divider answers only while the sequencer waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_XDIVW))
        else $error("divider result with no waiting step");

    // a new result is loaded only from the finishing step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside finish");
`endif
endmodule
